@@ design/mhpq_pkg.sv @@
// Shared commands and status codes of the max-heap priority queue.
package mhpq_pkg;

	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [STATUS_W-1:0]      status_t;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

endpackage

@@ design/max_heap_priority_queue_unit.sv @@
// An accepted insert sifts the new entry up; an accepted extract moves the last entry to the root
// and sifts it down. Either moves the entry through at most log2(CAPACITY) tree levels; a rejected
// insert or an extract on an empty heap goes straight to the result. Each level costs one synchronous
// memory read followed by a compare and write-back.
// One word is worked on at a time; the next word is taken only once the previous one
// has reached the output register. Reset empties the heap at once; the store is not cleared.
module max_heap_priority_queue_unit
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 127
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic signed [DATA_W-1:0]   value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic signed [DATA_W-1:0]   removed_value,
	output logic [COUNT_W-1:0]         entry_count,
	output logic signed [DATA_W-1:0]   top_value
);

	localparam int AW    = $clog2(CAPACITY + 1);
	localparam int DEPTH = 1 << AW;
	localparam int CW    = (AW > COUNT_W) ? AW : COUNT_W;
	localparam int LW    = CW + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_UP_RD  = 3'd1;
	localparam logic [2:0] S_UP_CMP = 3'd2;
	localparam logic [2:0] S_LAST   = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_CMP = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] pos_q, pos_d;
	data_t         hold_q, hold_d;
	data_t         top_q;
	status_t       stat_q, stat_d;
	data_t         rem_q, rem_d;

	// Output register.
	logic               ovalid_q;
	status_t            ostat_q;
	data_t              orem_q;
	logic [COUNT_W-1:0] ocount_q;
	data_t              otop_q;

	// Heap store with one write port and two read ports.
	data_t         mem [0:DEPTH-1];
	logic [AW-1:0] ra0, ra1, wa;
	data_t         rd0, rd1, wd;
	logic          we;

	// Child positions of the current node, wide enough to exceed the count.
	logic [LW-1:0] lc_w, rc_w, cnt_w, best_w;
	logic          lgt, rgt, rc_ok;
	data_t         cand;
	logic          out_free;

	assign lc_w   = LW'({pos_q, 1'b0});
	assign rc_w   = lc_w + LW'(1);
	assign cnt_w  = LW'(count_q);
	assign rc_ok  = (rc_w <= cnt_w);
	assign lgt    = (rd0 > hold_q);
	assign cand   = lgt ? rd0 : hold_q;
	assign rgt    = rc_ok && (rd1 > cand);
	assign best_w = rgt ? rc_w : lc_w;

	assign out_free = !ovalid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Read addresses: last entry on extract, parent on sift-up, children on sift-down.
	always_comb begin
		ra0 = lc_w[AW-1:0];
		if (state_q == S_IDLE) begin
			ra0 = count_q[AW-1:0];
		end else if (state_q == S_UP_RD) begin
			ra0 = pos_q >> 1;
		end
		ra1 = rc_w[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0 <= mem[ra0];
		rd1 <= mem[ra1];
	end

	// Sequencer for sift-up and sift-down with the moving entry held in a register.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d   = pos_q;
		hold_d  = hold_q;
		stat_d  = stat_q;
		rem_d   = rem_q;
		we      = 1'b0;
		wa      = pos_q;
		wd      = hold_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					rem_d  = '0;
					stat_d = STATUS_OK;
					if (command == CMD_INSERT) begin
						if (count_q == CW'(CAPACITY)) begin
							stat_d  = STATUS_FULL;
							state_d = S_DONE;
						end else begin
							count_d = count_q + CW'(1);
							pos_d   = AW'(count_q + CW'(1));
							hold_d  = value;
							state_d = S_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							stat_d  = STATUS_EMPTY;
							state_d = S_DONE;
						end else begin
							rem_d   = top_q;
							state_d = S_LAST;
						end
					end
				end
			end
			S_UP_RD: begin
				if (pos_q == AW'(1)) begin
					we      = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (hold_q > rd0) begin
					we      = 1'b1;
					wd      = rd0;
					pos_d   = pos_q >> 1;
					state_d = S_UP_RD;
				end else begin
					we      = 1'b1;
					state_d = S_DONE;
				end
			end
			S_LAST: begin
				hold_d  = rd0;
				count_d = count_q - CW'(1);
				pos_d   = AW'(1);
				state_d = S_DN_RD;
			end
			S_DN_RD: begin
				if (lc_w > cnt_w) begin
					we      = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (lgt || rgt) begin
					wd      = rgt ? rd1 : rd0;
					pos_d   = best_w[AW-1:0];
					state_d = S_DN_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == S_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Working and result payload registers.
	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		hold_q <= hold_d;
		stat_q <= stat_d;
		rem_q  <= rem_d;
		if (we && wa == AW'(1)) begin
			top_q <= wd;
		end
		if (state_q == S_DONE && out_free) begin
			ostat_q  <= stat_q;
			orem_q   <= rem_q;
			ocount_q <= count_q[COUNT_W-1:0];
			otop_q   <= (count_q == '0) ? '0 : top_q;
		end
	end

	assign out_valid     = ovalid_q;
	assign status        = ostat_q;
	assign removed_value = orem_q;
	assign entry_count   = ocount_q;
	assign top_value     = otop_q;

endmodule

@@ design/mhpq_checker.sv @@
// Port-level checks of the max-heap priority queue and their binding to the top level.
module mhpq_checker
	import mhpq_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic [STATUS_W-1:0]      status,
	input logic signed [DATA_W-1:0] removed_value,
	input logic [COUNT_W-1:0]       entry_count,
	input logic signed [DATA_W-1:0] top_value
);

	// Only one word is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in the cycle after an accepted word");

	// An empty extract leaves nothing behind and removes nothing.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_EMPTY |->
			entry_count == '0 && removed_value == '0 && top_value == '0)
		else $error("empty extract reported nonzero fields");

	// A rejected insert removes nothing.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FULL |-> removed_value == '0)
		else $error("full insert reported a removed value");

	// An empty heap has no top.
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count == '0 |-> top_value == '0)
		else $error("nonzero top value with no entries");

	// Only defined status codes leave the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STATUS_OK || status == STATUS_EMPTY || status == STATUS_FULL)
		else $error("undefined status code");

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.status        (status),
	.removed_value (removed_value),
	.entry_count   (entry_count),
	.top_value     (top_value)
);
